@@ rtl/core/srr_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// srr_pkg
// Shared types, constants and result builders for the selective-repeat
// receiver.
// ============================================================================
package srr_pkg;

    // Default parameter values
    localparam int RING_DEPTH_DEF    = 32;
    localparam int SEQ_BITS_DEF      = 16;
    localparam int PAYLOAD_BYTES_DEF = 20;

    // Fixed field sizes
    localparam int PAYLOAD_MAX = 20;
    localparam int WINDOW_W    = 6;
    localparam int SEQ_FIELD_W = 16;

    localparam logic [WINDOW_W-1:0] WINDOW_RST = 6'd8;

    // Result kinds and constant ACK fields
    localparam logic       KIND_DELIVER  = 1'b0;
    localparam logic       KIND_ACK      = 1'b1;
    localparam logic       ACK_SEQ_FIELD = 1'b1;
    localparam logic [7:0] ACK_DATA_BYTE = 8'd66;

    // Packet payload, byte 0 in the low bits of lo
    typedef struct packed {
        logic [31:0] hi;
        logic [63:0] mid;
        logic [63:0] lo;
    } t_payload;

    // One result item
    typedef struct packed {
        logic        kind;
        t_payload    payload;
        logic [15:0] ack_value;
        logic        ack_seq_field;
        logic [7:0]  ack_data_byte;
        logic [16:0] ack_checksum;
        logic        last;
    } t_result;

    // Build a delivery item
    function automatic t_result mk_deliver(input t_payload pl);
        t_result r;
        r               = '0;
        r.kind          = KIND_DELIVER;
        r.payload       = pl;
        return r;
    endfunction

    // Build an ACK item for a sequence number
    function automatic t_result mk_ack(input logic [15:0] seq);
        t_result r;
        r               = '0;
        r.kind          = KIND_ACK;
        r.ack_value     = seq;
        r.ack_seq_field = ACK_SEQ_FIELD;
        r.ack_data_byte = ACK_DATA_BYTE;
        r.ack_checksum  = 17'(seq) + 17'(ACK_SEQ_FIELD) + 17'(ACK_DATA_BYTE);
        r.last          = 1'b1;
        return r;
    endfunction

endpackage

@@ rtl/core/selective_repeat_receiver_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// selective_repeat_receiver_top
// Selective-repeat ARQ receiver: checksum, window decision, ring buffer of
// out-of-order payloads and in-order delivery followed by the ACK item.
// ============================================================================
// One packet is taken at a time. A packet that ends in an ACK only, or is
// dropped, passes through capture, byte group sums and the window decision
// with checksum compare before the next accept. A packet at the expected
// sequence number has its own delivery loaded into the output register in
// the decision step; once a scan finds the next slot empty, the ACK follows.
// Each buffered successor adds a scan and a fetch through the single read
// port of the slot memory (registered read) before it is shown. Output
// back-pressure holds each step that loads the output register. The next
// packet is accepted while the ACK of the previous one still waits in the
// output register.
// window_size 0 acts as 1, values above RING_DEPTH act as RING_DEPTH.
// Slot payloads have no reset; received flags are cleared by reset.
module selective_repeat_receiver_top #(
    parameter int RING_DEPTH    = srr_pkg::RING_DEPTH_DEF,
    parameter int SEQ_BITS      = srr_pkg::SEQ_BITS_DEF,
    parameter int PAYLOAD_BYTES = srr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // window_size register
    input  logic                          i_cfg_wr_en,
    input  logic [srr_pkg::WINDOW_W-1:0]  i_cfg_wr_data,
    // Input packets
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // low up: seq_number[15:0], ack_number[31:16], packet_checksum[63:32],
    // payload_low[127:64], payload_mid[191:128], payload_high[223:192]
    input  logic [223:0]                  s_axis_tdata,
    // Result items
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // low up: out_payload_low[63:0], out_payload_mid[127:64],
    // out_payload_high[159:128], ack_value[175:160], ack_seq_field[176],
    // ack_data_byte[184:177], ack_checksum[201:185], zero[207:202]
    output logic [207:0]                  m_axis_tdata,
    // kind[0]
    output logic [0:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);
    import srr_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_ACK  = 3'd5;

    // Control state
    logic [2:0]            r_state,    n_state;
    logic [WINDOW_W-1:0]   r_window;
    logic [SEQ_BITS-1:0]   r_expected, n_expected;
    logic [IDX_W-1:0]      r_head,     n_head;
    logic [RING_DEPTH-1:0] r_recv,     n_recv;
    logic                  r_out_valid, n_out_valid;
    t_result               r_out,       n_out;

    // Captured packet
    logic [15:0]           r_seq;
    logic [15:0]           r_ack;
    logic [31:0]           r_cks;
    t_payload              r_pl;
    logic [SEQ_BITS-1:0]   r_dist;

    logic                  in_fire;
    logic                  out_free;
    logic                  cks_ok;
    logic [SEQ_BITS-1:0]   seq_m;
    logic [SEQ_BITS-1:0]   neg_dist;
    logic [SEQ_BITS-1:0]   w_seq;
    logic [WINDOW_W-1:0]   w_eff;
    logic [IDX_W:0]        slot_sum;
    logic [IDX_W-1:0]      slot_idx;
    logic [IDX_W-1:0]      head_inc;
    logic                  mem_we;
    logic                  mem_re;
    t_payload              mem_rdata;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;

    // Checksum unit
    srr_checksum #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_checksum (
        .i_clk      (i_clk),
        .i_payload  (r_pl),
        .i_seq      (r_seq),
        .i_ack      (r_ack),
        .i_checksum (r_cks),
        .o_ok       (cks_ok)
    );

    // Slot payload memory
    srr_slot_mem #(
        .RING_DEPTH (RING_DEPTH),
        .IDX_W      (IDX_W)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (slot_idx),
        .i_wdata (r_pl),
        .i_re    (mem_re),
        .i_raddr (r_head),
        .o_rdata (mem_rdata)
    );

    // Window clamp and offset arithmetic
    always_comb begin
        if (r_window == '0) begin
            w_eff = WINDOW_W'(1);
        end else if (r_window > WINDOW_W'(RING_DEPTH)) begin
            w_eff = WINDOW_W'(RING_DEPTH);
        end else begin
            w_eff = r_window;
        end
        seq_m    = SEQ_BITS'(r_seq);
        neg_dist = '0 - r_dist;
        w_seq    = SEQ_BITS'(w_eff);
        slot_sum = {1'b0, r_head} + (IDX_W+1)'(r_dist);
        if (slot_sum >= (IDX_W+1)'(RING_DEPTH)) begin
            slot_idx = IDX_W'(slot_sum - (IDX_W+1)'(RING_DEPTH));
        end else begin
            slot_idx = slot_sum[IDX_W-1:0];
        end
        if (r_head == IDX_W'(RING_DEPTH - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = r_head + 1'b1;
        end
    end

    // Sequencer: decide, buffer, drain, acknowledge
    always_comb begin
        n_state     = r_state;
        n_expected  = r_expected;
        n_head      = r_head;
        n_recv      = r_recv;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (!cks_ok) begin
                    n_state = ST_IDLE;
                end else if (r_dist == '0) begin
                    // Deliver in-order packet, then scan successors
                    if (out_free) begin
                        n_out_valid    = 1'b1;
                        n_out          = mk_deliver(r_pl);
                        n_recv[r_head] = 1'b0;
                        n_head         = head_inc;
                        n_expected     = r_expected + 1'b1;
                        n_state        = ST_SCAN;
                    end
                end else if (r_dist < w_seq || neg_dist <= w_seq) begin
                    // Buffer in-window packet once, ACK either way
                    if (r_dist < w_seq && !r_recv[slot_idx]) begin
                        mem_we           = 1'b1;
                        n_recv[slot_idx] = 1'b1;
                    end
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out       = mk_ack(16'(seq_m));
                        n_state     = ST_IDLE;
                    end else begin
                        n_state     = ST_ACK;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (r_recv[r_head]) begin
                    mem_re  = 1'b1;
                    n_state = ST_RD;
                end else begin
                    n_state = ST_ACK;
                end
            end
            ST_RD: begin
                // Deliver the fetched slot and advance the ring
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_out          = mk_deliver(mem_rdata);
                    n_recv[r_head] = 1'b0;
                    n_head         = head_inc;
                    n_expected     = r_expected + 1'b1;
                    n_state        = ST_SCAN;
                end
            end
            ST_ACK: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = mk_ack(16'(seq_m));
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_window    <= WINDOW_RST;
            r_expected  <= '0;
            r_head      <= '0;
            r_recv      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_expected  <= n_expected;
            r_head      <= n_head;
            r_recv      <= n_recv;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_fire) begin
            r_seq    <= s_axis_tdata[15:0];
            r_ack    <= s_axis_tdata[31:16];
            r_cks    <= s_axis_tdata[63:32];
            r_pl.lo  <= s_axis_tdata[127:64];
            r_pl.mid <= s_axis_tdata[191:128];
            r_pl.hi  <= s_axis_tdata[223:192];
        end
        if (r_state == ST_SUM) begin
            r_dist <= seq_m - r_expected;
        end
    end

    // Output packing
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {6'd0, r_out.ack_checksum, r_out.ack_data_byte,
                            r_out.ack_seq_field, r_out.ack_value,
                            r_out.payload.hi, r_out.payload.mid,
                            r_out.payload.lo};

    // Memory writes only come from the decision step
    a_we_in_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_EVAL))
        else $error("slot write outside decision step");

    // A fetched slot must still be marked received
    a_rd_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD) |-> r_recv[r_head])
        else $error("draining an empty slot");

    // Delivering a fetched slot clears it
    a_rd_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD && out_free) |=> !r_recv[$past(r_head)])
        else $error("delivered slot not cleared");

    // Ring head and expected sequence advance together
    a_head_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_head != $past(r_head))
            |-> (r_expected == SEQ_BITS'($past(r_expected) + 1'b1)))
        else $error("ring head and expected sequence out of step");

endmodule

@@ rtl/core/srr_checksum.sv @@
`timescale 1ns / 1ps
// ============================================================================
// srr_checksum
// Additive packet check: signed payload bytes up to the first zero byte,
// summed in registered groups, then added to seq and ack and compared.
// ============================================================================
module srr_checksum #(
    parameter int PAYLOAD_BYTES = srr_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                 i_clk,
    input  srr_pkg::t_payload    i_payload,
    input  logic [15:0]          i_seq,
    input  logic [15:0]          i_ack,
    input  logic [31:0]          i_checksum,
    output logic                 o_ok
);
    import srr_pkg::*;

    localparam int GRP_N    = 4;
    localparam int GRP_SIZE = PAYLOAD_MAX / GRP_N;

    logic [PAYLOAD_MAX*8-1:0] bytes;
    logic [PAYLOAD_MAX-1:0]   nz;
    logic [PAYLOAD_MAX-1:0]   live;
    logic signed [10:0]       grp_sum [GRP_N];
    logic signed [10:0]       r_grp   [GRP_N];
    logic [19:0]              total;

    assign bytes = {i_payload.hi, i_payload.mid, i_payload.lo};

    // Mark bytes that count: inside the payload length and before the first zero
    always_comb begin
        for (int i = 0; i < PAYLOAD_MAX; i++) begin
            nz[i] = (|bytes[8*i +: 8]) && (i < PAYLOAD_BYTES);
        end
        for (int i = 0; i < PAYLOAD_MAX; i++) begin
            live[i] = &(nz | ~(PAYLOAD_MAX'((64'd1 << (i + 1)) - 64'd1)));
        end
    end

    // Sum each group of signed bytes
    always_comb begin
        for (int g = 0; g < GRP_N; g++) begin
            grp_sum[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++) begin
                if (live[g*GRP_SIZE + j]) begin
                    grp_sum[g] = grp_sum[g]
                               + 11'(signed'(bytes[8*(g*GRP_SIZE + j) +: 8]));
                end
            end
        end
    end

    // Hold group sums for the compare cycle
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < GRP_N; g++) begin
            r_grp[g] <= grp_sum[g];
        end
    end

    // Add header fields and compare against the carried checksum
    always_comb begin
        total = 20'(i_seq) + 20'(i_ack);
        for (int g = 0; g < GRP_N; g++) begin
            total = total + 20'(r_grp[g]);
        end
    end

    assign o_ok = ({{12{total[19]}}, total} == i_checksum);

endmodule

@@ rtl/core/srr_slot_mem.sv @@
`timescale 1ns / 1ps
// ============================================================================
// srr_slot_mem
// Ring buffer payload store: one write port, one read port, registered read.
// ============================================================================
module srr_slot_mem #(
    parameter int RING_DEPTH = srr_pkg::RING_DEPTH_DEF,
    parameter int IDX_W      = $clog2(RING_DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [IDX_W-1:0]     i_waddr,
    input  srr_pkg::t_payload    i_wdata,
    input  logic                 i_re,
    input  logic [IDX_W-1:0]     i_raddr,
    output srr_pkg::t_payload    o_rdata
);
    import srr_pkg::*;

    t_payload mem [RING_DEPTH];

    // Write buffered packet
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

@@ verif/tb_selective_repeat_receiver_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_selective_repeat_receiver_top
// Self-checking bench for the selective-repeat receiver. A directed table
// walks the window edges, checksum failures, duplicates and delivery runs.
// Random bursts of in-window packets follow, sent in shuffled order, along
// with stale, far and corrupt packets. Every result item is compared field
// by field with the expected items from the table or from a local model of
// the receive window and slot ring, under random source gaps and sink stalls.
// ============================================================================
module tb_selective_repeat_receiver_top;
    import srr_pkg::*;

    localparam int RING_SLOTS   = 32;
    localparam int SEQ_SPAN     = 65536;
    localparam int DRAIN_CYCLES = 8;
    localparam int END_CYCLES   = 40;
    localparam int RANDOM_ITEMS = 380;
    localparam int MAX_REPORTS  = 10;
    localparam int TIMEOUT_NS   = 40_000_000;

    typedef enum {CHK_MODEL, CHK_NONE, CHK_ACK, CHK_DELIVER_ACK} t_check;
    typedef enum {ROW_PKT, ROW_WIN} t_row_op;

    typedef struct packed {
        t_payload    pl;
        logic [31:0] csum;
        logic [15:0] ack;
        logic [15:0] seq;
    } t_packet;

    typedef struct {
        t_row_op               op;
        t_packet               pkt;
        t_check                chk;
        logic [WINDOW_W-1:0]   win;
    } t_row;

    // DUT signals
    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [WINDOW_W-1:0] i_cfg_wr_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [223:0]        s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [207:0]        m_axis_tdata;
    logic [0:0]          m_axis_tuser;
    logic                m_axis_tlast;

    // Receiver model state
    logic [15:0]         exp_seq = '0;
    logic [4:0]          head    = '0;
    bit                  held [RING_SLOTS];
    t_payload            stored [RING_SLOTS];
    logic [WINDOW_W-1:0] window  = WINDOW_RST;

    t_result             pending_items [$];
    t_row                plan [$];
    int                  mismatches = 0;
    int                  useful     = 0;
    bit                  calm       = 1'b0;

    selective_repeat_receiver_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int eff_window();
        int w;
        w = int'(window);
        if (w < 1) w = 1;
        if (w > RING_SLOTS) w = RING_SLOTS;
        return w;
    endfunction

    // Seq + ack + signed payload bytes up to the first zero byte
    function automatic logic [31:0] packet_sum(input t_packet p);
        logic [31:0] sum;
        logic [7:0]  b;
        sum = 32'(p.seq) + 32'(p.ack);
        for (int i = 0; i < PAYLOAD_MAX; i++) begin
            b = p.pl[8*i +: 8];
            if (b == 8'd0) break;
            sum = sum + {{24{b[7]}}, b};
        end
        return sum;
    endfunction

    function automatic t_packet make_packet(input logic [15:0] seq, input logic [15:0] ack,
                                            input t_payload pl, input bit bad);
        t_packet p;
        p.seq  = seq;
        p.ack  = ack;
        p.pl   = pl;
        p.csum = packet_sum(p);
        if (bad) p.csum = p.csum ^ (32'd1 << $urandom_range(0, 31));
        return p;
    endfunction

    function automatic t_payload rand_payload();
        t_payload pl;
        pl.lo  = {$urandom, $urandom};
        pl.mid = {$urandom, $urandom};
        pl.hi  = $urandom;
        // Cut the checksum span short at a random byte
        if ($urandom_range(0, 3) == 0) pl[8*$urandom_range(0, PAYLOAD_MAX-1) +: 8] = 8'd0;
        return pl;
    endfunction

    function automatic t_result deliver_item(input t_payload pl);
        t_result r;
        r         = '0;
        r.kind    = KIND_DELIVER;
        r.payload = pl;
        return r;
    endfunction

    function automatic t_result ack_item(input logic [15:0] seq);
        t_result r;
        r               = '0;
        r.kind          = KIND_ACK;
        r.ack_value     = seq;
        r.ack_seq_field = ACK_SEQ_FIELD;
        r.ack_data_byte = ACK_DATA_BYTE;
        r.ack_checksum  = 17'(seq) + 17'd1 + 17'd66;
        r.last          = 1'b1;
        return r;
    endfunction

    // Advance the window model for one packet; queue its results when keep is set
    task automatic receive_packet(input t_packet p, input bit keep, output int n);
        logic [15:0] d;
        int          w;
        logic [4:0]  slot;
        n = 0;
        w = eff_window();
        if (packet_sum(p) != p.csum) return;
        d = p.seq - exp_seq;
        if (d == 16'd0) begin
            if (keep) pending_items.push_back(deliver_item(p.pl));
            n++;
            held[head] = 1'b0;
            head    = head + 5'd1;
            exp_seq = exp_seq + 16'd1;
            // Drain buffered successors regardless of the current window
            for (int k = 1; k < RING_SLOTS; k++) begin
                if (!held[head]) break;
                if (keep) pending_items.push_back(deliver_item(stored[head]));
                n++;
                held[head] = 1'b0;
                head    = head + 5'd1;
                exp_seq = exp_seq + 16'd1;
            end
        end else if (int'(d) < w) begin
            slot = head + d[4:0];
            if (!held[slot]) begin
                held[slot]   = 1'b1;
                stored[slot] = p.pl;
            end
        end else if (int'(d) < SEQ_SPAN - w) begin
            return;
        end
        if (keep) pending_items.push_back(ack_item(p.seq));
        n++;
    endtask

    // Present one packet, hold until accepted, then record what it should cause
    task automatic send_packet(input t_packet p, input t_check chk, output int n);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = p;
        do @(posedge i_clk); while (!s_axis_tready);
        receive_packet(p, chk == CHK_MODEL, n);
        case (chk)
            CHK_ACK: begin
                pending_items.push_back(ack_item(p.seq));
            end
            CHK_DELIVER_ACK: begin
                pending_items.push_back(deliver_item(p.pl));
                pending_items.push_back(ack_item(p.seq));
            end
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Write the window register once the block has gone quiet
    task automatic set_window(input logic [WINDOW_W-1:0] v);
        s_axis_tvalid = 1'b0;
        while (pending_items.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        window        = v;
    endtask

    task automatic add_pkt(input logic [15:0] seq, input logic [15:0] ack, input t_payload pl,
                           input bit bad, input t_check chk);
        t_row r;
        r.op  = ROW_PKT;
        r.pkt = make_packet(seq, ack, pl, bad);
        r.chk = chk;
        r.win = '0;
        plan.push_back(r);
    endtask

    task automatic add_win(input logic [WINDOW_W-1:0] v);
        t_row r;
        r.op  = ROW_WIN;
        r.pkt = '0;
        r.chk = CHK_NONE;
        r.win = v;
        plan.push_back(r);
    endtask

    // Send a run of sequence numbers from the window base in scrambled order;
    // a fill buffers all other ring slots before the base packet arrives
    task automatic run_burst(input int k, input bit fill);
        logic [15:0] base;
        int          order [$];
        int          j, tmp, n;
        t_packet     p;
        base = exp_seq;
        if (fill) k = RING_SLOTS;
        for (int i = 1; i < k; i++) order.push_back(i);
        if (!fill) order.push_back(0);
        for (int i = order.size() - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        if ($urandom_range(0, 3) == 0) order.reverse();
        if (!fill && $urandom_range(0, 4) == 0)
            order.insert($urandom_range(0, order.size()), order[$urandom_range(0, k-1)]);
        if (fill) order.push_back(0);
        foreach (order[i]) begin
            p = make_packet(base + 16'(order[i]), 16'($urandom), rand_payload(),
                            !fill && $urandom_range(0, 9) == 0);
            send_packet(p, CHK_MODEL, n);
            if (n > 0) useful++;
        end
    endtask

    // Stale, nearby or arbitrary packets, some corrupt
    task automatic send_stray();
        t_packet     p;
        logic [15:0] s;
        int          n;
        case ($urandom_range(0, 3))
            0:       s = exp_seq - 16'($urandom_range(1, 40));
            1:       s = exp_seq + 16'($urandom_range(0, 63));
            default: s = 16'($urandom);
        endcase
        p = make_packet(s, 16'($urandom), rand_payload(), $urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0) p.csum = $urandom;
        send_packet(p, CHK_MODEL, n);
        if (n > 0) useful++;
    endtask

    // Sink side: random stalls on the result stream
    initial begin : sink_ctl
        int stall;
        stall         = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                stall--;
            end else begin
                m_axis_tready = 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    // Compare each accepted result item with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result got, want;
        string   diff;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind          = m_axis_tuser[0];
            got.payload.lo    = m_axis_tdata[63:0];
            got.payload.mid   = m_axis_tdata[127:64];
            got.payload.hi    = m_axis_tdata[159:128];
            got.ack_value     = m_axis_tdata[175:160];
            got.ack_seq_field = m_axis_tdata[176];
            got.ack_data_byte = m_axis_tdata[184:177];
            got.ack_checksum  = m_axis_tdata[201:185];
            got.last          = m_axis_tlast;
            if (pending_items.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result item %h", $time, got);
            end else begin
                want = pending_items.pop_front();
                diff = "";
                if (got.kind != want.kind)                   diff = {diff, " kind"};
                if (got.payload.lo != want.payload.lo)       diff = {diff, " payload_lo"};
                if (got.payload.mid != want.payload.mid)     diff = {diff, " payload_mid"};
                if (got.payload.hi != want.payload.hi)       diff = {diff, " payload_hi"};
                if (got.ack_value != want.ack_value)         diff = {diff, " ack_value"};
                if (got.ack_seq_field != want.ack_seq_field) diff = {diff, " ack_seq_field"};
                if (got.ack_data_byte != want.ack_data_byte) diff = {diff, " ack_data_byte"};
                if (got.ack_checksum != want.ack_checksum)   diff = {diff, " ack_checksum"};
                if (got.last != want.last)                   diff = {diff, " last"};
                if (m_axis_tdata[207:202] != 6'd0)           diff = {diff, " pad"};
                if (diff != "") begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: mismatch in%s: expected %h got %h",
                                 $time, diff, want, got);
                end
            end
        end
    end

    // Stimulus: directed table, then random bursts and strays
    initial begin : stimulus
        int                  n;
        int                  sel;
        logic [WINDOW_W-1:0] v;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        // Window 8 after reset, base 0
        add_pkt(16'h0000, 16'hFFFF, '1, 1'b0, CHK_DELIVER_ACK);
        add_pkt(16'h0001, 16'h1234, rand_payload(), 1'b1, CHK_NONE);
        add_pkt(16'h0000, 16'h0000, '0, 1'b0, CHK_ACK);
        add_pkt(16'h0003, 16'h00A5,
                {32'h00FF_8001, 64'h0102_0304_0506_0708, 64'h7F80_017F_80FF_0181},
                1'b0, CHK_ACK);
        // Duplicate must not overwrite the buffered copy
        add_pkt(16'h0003, 16'h5A00, rand_payload(), 1'b0, CHK_ACK);
        add_pkt(16'h0002, 16'h0042, rand_payload(), 1'b0, CHK_ACK);
        add_pkt(16'h0008, 16'h8000, rand_payload(), 1'b0, CHK_ACK);
        add_pkt(16'h0009, 16'h0001, rand_payload(), 1'b0, CHK_NONE);
        add_pkt(16'h0001, 16'h7FFF, rand_payload(), 1'b0, CHK_MODEL);
        // Below-window edge: re-ACK down to base minus window, drop below that
        add_pkt(16'hFFFF, 16'hFFFF, '1, 1'b0, CHK_ACK);
        add_pkt(16'hFFFC, 16'h0000, rand_payload(), 1'b0, CHK_ACK);
        add_pkt(16'hFFFB, 16'h0000, rand_payload(), 1'b0, CHK_NONE);
        // Window 0 acts as 1
        add_win(6'd0);
        add_pkt(16'h0005, 16'h0003, rand_payload(), 1'b0, CHK_NONE);
        add_pkt(16'h0003, 16'h0003, rand_payload(), 1'b0, CHK_ACK);
        add_pkt(16'h0002, 16'h0003, rand_payload(), 1'b0, CHK_NONE);
        // Window 63 acts as 32
        add_win(6'd63);
        add_pkt(16'd35, 16'h0C0C, rand_payload(), 1'b0, CHK_ACK);
        add_pkt(16'd36, 16'h0C0C, rand_payload(), 1'b0, CHK_NONE);
        add_win(6'd32);
        add_pkt(16'h0004, 16'h3333, rand_payload(), 1'b0, CHK_DELIVER_ACK);
        // Shrunk window still drains a slot buffered under a wider one
        add_win(6'd1);
        add_pkt(16'h0005, 16'h0000, rand_payload(), 1'b0, CHK_DELIVER_ACK);
        add_pkt(16'h0006, 16'h0000, rand_payload(), 1'b0, CHK_DELIVER_ACK);
        add_pkt(16'h0007, 16'h0000, rand_payload(), 1'b0, CHK_MODEL);
        add_win(WINDOW_RST);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table with no gaps, then with gaps
        calm = 1'b1;
        foreach (plan[i]) begin
            if (i == plan.size() / 2) calm = 1'b0;
            if (plan[i].op == ROW_WIN) set_window(plan[i].win);
            else send_packet(plan[i].pkt, plan[i].chk, n);
        end

        // Random part opens with a full ring drain
        set_window(6'd32);
        run_burst(0, 1'b1);
        while (useful < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 4))
                    0:       v = 6'd0;
                    1:       v = 6'd1;
                    2:       v = 6'd32;
                    3:       v = 6'd63;
                    default: v = 6'($urandom_range(2, 31));
                endcase
                set_window(v);
            end
            calm = ($urandom_range(0, 4) == 0);
            sel  = $urandom_range(0, 99);
            if (sel < 60) begin
                run_burst($urandom_range(1, eff_window()), 1'b0);
            end else if (sel < 66) begin
                if (eff_window() != RING_SLOTS) set_window($urandom_range(0, 1) ? 6'd32 : 6'd63);
                run_burst(0, 1'b1);
            end else begin
                repeat ($urandom_range(1, 4)) send_stray();
            end
        end

        // Let the last results drain
        s_axis_tvalid = 1'b0;
        calm          = 1'b0;
        while (pending_items.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/srr_pkg.sv
rtl/core/srr_checksum.sv
rtl/core/srr_slot_mem.sv
rtl/core/selective_repeat_receiver_top.sv
verif/tb_selective_repeat_receiver_top.sv
